FILE: sv/frfifo_pkg.sv
// Shared types for the frame-aligned ring FIFO.
// Holds the opcode codes, the classified command and the result record.
// No dependencies.
package frfifo_pkg;

   localparam int FRAME_W = 32;
   localparam int WRAP_W  = 32;
   localparam int BYTES_W = 16;
   localparam int REQ_W   = 30;

   typedef enum logic [1:0] {
      OP_SEND_START = 2'd0,
      OP_SEND_FRAME = 2'd1,
      OP_RECV_START = 2'd2,
      OP_RECV_FRAME = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               len_ok;
      logic [REQ_W-1:0]   frames;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   typedef struct packed {
      logic [BYTES_W-1:0] granted_bytes;
      logic [FRAME_W-1:0] frame_out;
      logic               frame_valid;
      logic               frame_taken;
      logic [BYTES_W-1:0] fill_bytes;
      logic [WRAP_W-1:0]  write_wraps;
      logic [WRAP_W-1:0]  read_wraps;
   } rsp_type;

endpackage

FILE: sv/frfifo_front.sv
// Front end of the frame-aligned ring FIFO: accepts request transfers,
// classifies them and holds them in a two-entry command queue.
// Depends on frfifo_pkg.
module frfifo_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_opcode,
   input  logic [31:0]                 req_block_bytes,
   input  logic [31:0]                 req_frame_in,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output frfifo_pkg::cmd_type         cmd
);

   frfifo_pkg::cmd_type cmd_q_ff [2];
   frfifo_pkg::cmd_type new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      new_cmd.opcode = frfifo_pkg::opcode_type'(req_opcode);
      new_cmd.len_ok = (req_block_bytes != 32'd0) && (req_block_bytes[1:0] == 2'b00);
      new_cmd.frames = req_block_bytes[31:2];
      new_cmd.frame  = req_frame_in;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: sv/frfifo_back.sv
// Back end of the frame-aligned ring FIFO: executes commands against the
// frame store, keeps positions, grants and wrap counters, queues results.
// Depends on frfifo_pkg.
module frfifo_back #(
   parameter int RING_BYTES = 32768
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  frfifo_pkg::cmd_type cmd,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output frfifo_pkg::rsp_type rsp
);

   localparam int FRAMES = RING_BYTES / 4;
   localparam int IDX_W  = $clog2(FRAMES);
   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int SUM_W  = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_GRANT = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] ring_mem [FRAMES];
   logic [31:0] rdata_ff;
   logic        mem_we, mem_re;

   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] send_left_ff, send_left_in;
   logic [CNT_W-1:0] recv_left_ff, recv_left_in;
   logic [CNT_W-1:0] grant_ff, grant_in;
   logic             grant_send_ff, grant_send_in;
   logic [31:0]      wwrap_ff, wwrap_in;
   logic [31:0]      rwrap_ff, rwrap_in;

   logic [CNT_W-1:0] free_frames;
   logic [CNT_W-1:0] send_grant;
   logic [CNT_W-1:0] recv_grant;
   logic [SUM_W-1:0] span_end;
   logic             crosses;

   frfifo_pkg::rsp_type outq_ff [2];
   frfifo_pkg::rsp_type res;
   logic       res_push;
   logic       oq_wr_ff, oq_wr_in;
   logic       oq_rd_ff, oq_rd_in;
   logic [1:0] oq_cnt_ff, oq_cnt_in;
   logic       oq_pop;

   assign free_frames = CNT_W'(FRAMES) - fill_ff;
   assign send_grant  = !cmd.len_ok ? '0 :
                        ((cmd.frames < frfifo_pkg::REQ_W'(free_frames)) ?
                         CNT_W'(cmd.frames) : free_frames);
   assign recv_grant  = (cmd.frames < frfifo_pkg::REQ_W'(fill_ff)) ?
                        CNT_W'(cmd.frames) : fill_ff;
   assign span_end    = SUM_W'(grant_ff) + SUM_W'(grant_send_ff ? widx_ff : ridx_ff);
   assign crosses     = (grant_ff != '0) && (span_end > SUM_W'(FRAMES));

   assign cmd_ready = (state_ff == ST_IDLE) && (oq_cnt_ff != 2'd2);

   always_comb begin
      state_in      = state_ff;
      widx_in       = widx_ff;
      ridx_in       = ridx_ff;
      fill_in       = fill_ff;
      send_left_in  = send_left_ff;
      recv_left_in  = recv_left_ff;
      grant_in      = grant_ff;
      grant_send_in = grant_send_ff;
      wwrap_in      = wwrap_ff;
      rwrap_in      = rwrap_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      res_push      = 1'b0;
      res           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               case (cmd.opcode)
                  frfifo_pkg::OP_SEND_START: begin
                     send_left_in  = '0;
                     grant_in      = send_grant;
                     grant_send_in = 1'b1;
                     state_in      = ST_GRANT;
                  end
                  frfifo_pkg::OP_SEND_FRAME: begin
                     if ((send_left_ff != '0) && (fill_ff != CNT_W'(FRAMES))) begin
                        mem_we       = 1'b1;
                        widx_in      = (widx_ff == IDX_W'(FRAMES - 1)) ? '0 :
                                       widx_ff + IDX_W'(1);
                        send_left_in = send_left_ff - CNT_W'(1);
                        fill_in      = fill_ff + CNT_W'(1);
                        res.frame_taken = 1'b1;
                     end
                     res_push = 1'b1;
                  end
                  frfifo_pkg::OP_RECV_START: begin
                     grant_in      = recv_grant;
                     recv_left_in  = recv_grant;
                     grant_send_in = 1'b0;
                     state_in      = ST_GRANT;
                  end
                  frfifo_pkg::OP_RECV_FRAME: begin
                     if ((recv_left_ff != '0) && (fill_ff != '0)) begin
                        mem_re       = 1'b1;
                        ridx_in      = (ridx_ff == IDX_W'(FRAMES - 1)) ? '0 :
                                       ridx_ff + IDX_W'(1);
                        recv_left_in = recv_left_ff - CNT_W'(1);
                        fill_in      = fill_ff - CNT_W'(1);
                        state_in     = ST_READ;
                     end else begin
                        res_push = 1'b1;
                     end
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         ST_GRANT: begin
            if (grant_send_ff) begin
               send_left_in = grant_ff;
               if (crosses) begin
                  wwrap_in = wwrap_ff + 32'd1;
               end
            end else if (crosses) begin
               rwrap_in = rwrap_ff + 32'd1;
            end
            res.granted_bytes = frfifo_pkg::BYTES_W'({grant_ff, 2'b00});
            res_push          = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_READ: begin
            res.frame_out   = rdata_ff;
            res.frame_valid = 1'b1;
            res_push        = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      res.fill_bytes  = frfifo_pkg::BYTES_W'({fill_in, 2'b00});
      res.write_wraps = wwrap_in;
      res.read_wraps  = rwrap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         widx_ff       <= '0;
         ridx_ff       <= '0;
         fill_ff       <= '0;
         send_left_ff  <= '0;
         recv_left_ff  <= '0;
         grant_ff      <= '0;
         grant_send_ff <= 1'b0;
         wwrap_ff      <= '0;
         rwrap_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         widx_ff       <= widx_in;
         ridx_ff       <= ridx_in;
         fill_ff       <= fill_in;
         send_left_ff  <= send_left_in;
         recv_left_ff  <= recv_left_in;
         grant_ff      <= grant_in;
         grant_send_ff <= grant_send_in;
         wwrap_ff      <= wwrap_in;
         rwrap_ff      <= rwrap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[widx_ff] <= cmd.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= ring_mem[ridx_ff];
      end
   end

   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp       = outq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = res_push ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (res_push && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 2'd1;
      end else if (oq_pop && !res_push) begin
         oq_cnt_in = oq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         outq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

FILE: sv/frame_aligned_ring_fifo_top.sv
// Top level of the frame-aligned ring FIFO of 4-byte stereo frames.
// Instantiates frfifo_front and frfifo_back; depends on frfifo_pkg.
//
// Request channel (req_): a transfer happens when req_push is high and
// req_full is low. req_opcode selects send start, send frame, receive
// start or receive frame; req_block_bytes sizes a start, req_frame_in
// carries the frame of a send frame.
// Result channel (rsp_): one result per request, in request order. The
// oldest result sits on the rsp_ ports while rsp_empty is low and is
// transferred when rsp_pop is high.
// Timing: a request enters a two-entry command queue, the back end takes
// one command at a time. Send frame and a refused receive frame finish in
// the idle state; a start passes on to the grant state and a receive frame
// that pops to the read state, which waits on the registered read port of
// the frame store. The back end takes no new command until it is idle again
// and the result queue has room.
// Reset: synchronous; clears positions, fill, grants, wrap counters and
// both queues. Store contents are not cleared and are never read unwritten.
// Stall: with rsp_pop low the two-entry result queue fills, the back end
// holds, then the command queue fills and req_full rises. Nothing is lost.
module frame_aligned_ring_fifo_top #(
   parameter int RING_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_block_bytes,
   input  logic [31:0] req_frame_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_granted_bytes,
   output logic [31:0] rsp_frame_out,
   output logic        rsp_frame_valid,
   output logic        rsp_frame_taken,
   output logic [15:0] rsp_fill_bytes,
   output logic [31:0] rsp_write_wraps,
   output logic [31:0] rsp_read_wraps
);

   frfifo_pkg::cmd_type cmd;
   frfifo_pkg::rsp_type rsp;
   logic                cmd_valid;
   logic                cmd_ready;

   frfifo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_block_bytes (req_block_bytes),
      .req_frame_in    (req_frame_in),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   frfifo_back #(
      .RING_BYTES (RING_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_granted_bytes = rsp.granted_bytes;
   assign rsp_frame_out     = rsp.frame_out;
   assign rsp_frame_valid   = rsp.frame_valid;
   assign rsp_frame_taken   = rsp.frame_taken;
   assign rsp_fill_bytes    = rsp.fill_bytes;
   assign rsp_write_wraps   = rsp.write_wraps;
   assign rsp_read_wraps    = rsp.read_wraps;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for frame_aligned_ring_fifo_top: directed, ring-capacity and random
// traffic, each result checked against a local model of the frame ring.
// Depends on frfifo_pkg and the RTL of the block.
module testbench;

   localparam int RING_BYTES      = 32768;
   localparam int RING_FRAMES     = RING_BYTES / 4;
   localparam int RANDOM_ITEMS    = 1400;
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_opcode = frfifo_pkg::OP_SEND_START;
   logic [31:0] req_block_bytes = '0;
   logic [31:0] req_frame_in = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_granted_bytes;
   logic [31:0] rsp_frame_out;
   logic        rsp_frame_valid;
   logic        rsp_frame_taken;
   logic [15:0] rsp_fill_bytes;
   logic [31:0] rsp_write_wraps;
   logic [31:0] rsp_read_wraps;

   logic [31:0] ring_mem [RING_FRAMES];
   logic [13:0] wr_pos = '0;
   logic [13:0] rd_pos = '0;
   logic [13:0] send_left = '0;
   logic [13:0] recv_left = '0;
   logic [31:0] wr_wraps = '0;
   logic [31:0] rd_wraps = '0;

   frfifo_pkg::rsp_type outcomes_due[$];
   int          failures = 0;
   longint      cycle_count = 0;
   int          burst_left = 0;
   logic [7:0]  pop_pattern = 8'hFF;
   logic [2:0]  pop_phase = '0;

   frame_aligned_ring_fifo_top uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("frame_aligned_ring_fifo_top: mismatch");
         $finish;
      end
   end

   function automatic int unsigned frames_held();
      logic [13:0] diff;
      diff = wr_pos - rd_pos;
      return 32'(diff);
   endfunction

   function automatic bit span_wraps(logic [13:0] pos, int unsigned frames);
      return frames > RING_FRAMES - pos[12:0];
   endfunction

   task automatic ring_outcome(input frfifo_pkg::opcode_type op, input logic [31:0] blk,
                               input logic [31:0] frm, output frfifo_pkg::rsp_type r);
      int unsigned fill;
      int unsigned free_b;
      int unsigned grant;
      int unsigned req_b;
      r = '0;
      grant = 0;
      fill = frames_held();
      case (op)
         frfifo_pkg::OP_SEND_START: begin
            send_left = '0;
            if (blk != 0 && blk[1:0] == 2'b00) begin
               free_b = RING_BYTES - fill * 4;
               grant = (blk < free_b) ? blk : free_b;
               if (grant != 0) begin
                  if (span_wraps(wr_pos, grant / 4))
                     wr_wraps++;
                  send_left = 14'(grant / 4);
               end
            end
         end
         frfifo_pkg::OP_SEND_FRAME: begin
            if (send_left != 0 && fill < RING_FRAMES) begin
               ring_mem[wr_pos[12:0]] = frm;
               wr_pos++;
               send_left--;
               r.frame_taken = 1'b1;
            end
         end
         frfifo_pkg::OP_RECV_START: begin
            req_b = {blk[31:2], 2'b00};
            grant = (req_b < fill * 4) ? req_b : fill * 4;
            recv_left = 14'(grant / 4);
            if (grant != 0 && span_wraps(rd_pos, grant / 4))
               rd_wraps++;
         end
         frfifo_pkg::OP_RECV_FRAME: begin
            if (recv_left != 0 && fill != 0) begin
               r.frame_out = ring_mem[rd_pos[12:0]];
               rd_pos++;
               recv_left--;
               r.frame_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.granted_bytes = grant[15:0];
      r.fill_bytes    = 16'(frames_held() * 4);
      r.write_wraps   = wr_wraps;
      r.read_wraps    = rd_wraps;
   endtask

   task automatic push_item(input frfifo_pkg::opcode_type op, input logic [31:0] blk,
                            input logic [31:0] frm);
      frfifo_pkg::rsp_type r;
      int gap;
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_block_bytes <= blk;
      req_frame_in    <= frm;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      ring_outcome(op, blk, frm, r);
      outcomes_due.push_back(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 31);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_check
      frfifo_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (outcomes_due.size() == 0) begin
            $error("transfer on rsp_ with no result outstanding");
            failures++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("granted_bytes", want.granted_bytes, rsp_granted_bytes);
            check_field("frame_out", want.frame_out, rsp_frame_out);
            check_field("frame_valid", want.frame_valid, rsp_frame_valid);
            check_field("frame_taken", want.frame_taken, rsp_frame_taken);
            check_field("fill_bytes", want.fill_bytes, rsp_fill_bytes);
            check_field("write_wraps", want.write_wraps, rsp_write_wraps);
            check_field("read_wraps", want.read_wraps, rsp_read_wraps);
         end
      end
      if (pop_phase == 0 && $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: pop_pattern = 8'hFF;
            1: pop_pattern = 8'h01;
            default: pop_pattern = 8'($urandom_range(1, 255));
         endcase
      end
      rsp_pop <= pop_pattern[pop_phase];
      pop_phase = pop_phase + 3'd1;
   end

   task automatic test_refused_blocks();
      push_item(frfifo_pkg::OP_SEND_START, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, 32'h1234_5678);
      push_item(frfifo_pkg::OP_SEND_START, 32'd6, 32'd0);
      push_item(frfifo_pkg::OP_SEND_START, 32'hFFFF_FFFF, 32'd0);
   endtask

   task automatic test_frames_without_grant();
      push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_RECV_START, 32'hFFFF_FFFF, 32'd0);
      push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
   endtask

   task automatic test_grants_and_pops();
      push_item(frfifo_pkg::OP_SEND_START, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_SEND_START, 32'd8, 32'd0);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, 32'hA5C3_0F96);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, 32'h0102_0304);
      push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, 32'h5A3C_F069);
      push_item(frfifo_pkg::OP_RECV_START, 32'd7, 32'd0);
      push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_RECV_START, 32'd13, 32'd0);
      push_item(frfifo_pkg::OP_RECV_START, 32'hFFFF_FFFF, 32'd0);
      repeat (4) push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
   endtask

   task automatic test_write_wrap();
      push_item(frfifo_pkg::OP_SEND_START, RING_BYTES, 32'd0);
   endtask

   task automatic test_ring_capacity();
      int held;
      held = frames_held();
      push_item(frfifo_pkg::OP_RECV_START, 32'hFFFF_FFFC, 32'd0);
      repeat (held) push_item(frfifo_pkg::OP_RECV_FRAME, 32'd0, 32'd0);
      push_item(frfifo_pkg::OP_SEND_START, RING_BYTES, 32'd0);
      repeat (40) push_item(frfifo_pkg::OP_SEND_FRAME, $urandom, $urandom);
      push_item(frfifo_pkg::OP_SEND_START, RING_BYTES, 32'd0);
      repeat (2) push_item(frfifo_pkg::OP_SEND_FRAME, 32'd0, $urandom);
      push_item(frfifo_pkg::OP_RECV_START, 32'hFFFF_FFFF, 32'd0);
      repeat (43) push_item(frfifo_pkg::OP_RECV_FRAME, $urandom, $urandom);
   endtask

   task automatic test_random_traffic();
      int sent;
      int k;
      int n;
      int pick;
      logic [31:0] len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            k = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
               0: len = $urandom;
               1: len = 4 * $urandom_range(1, RING_FRAMES);
               default: len = 4 * k;
            endcase
            n = k + $urandom_range(0, 3) - 1;
            push_item(frfifo_pkg::OP_SEND_START, len, $urandom);
            repeat (n) push_item(frfifo_pkg::OP_SEND_FRAME, $urandom, $urandom);
            sent += n + 1;
         end else if (pick < 80) begin
            len = $urandom_range(0, 99);
            n = len / 4 + $urandom_range(0, 2);
            push_item(frfifo_pkg::OP_RECV_START, len, $urandom);
            repeat (n) push_item(frfifo_pkg::OP_RECV_FRAME, $urandom, $urandom);
            sent += n + 1;
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_item(frfifo_pkg::opcode_type'($urandom_range(0, 3)),
                                 $urandom, $urandom);
            sent += n;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_refused_blocks();
      test_frames_without_grant();
      test_grants_and_pops();
      test_write_wrap();
      test_ring_capacity();
      test_random_traffic();
      req_push <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0)
         $display("frame_aligned_ring_fifo_top: match");
      else
         $display("frame_aligned_ring_fifo_top: mismatch");
      $finish;
   end

endmodule
